[hw/rtl/pipm_pkg.sv]
// Shared constants, register codes and width helpers for the inverse perspective pixel map.
`default_nettype none

package pipm_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int STEP_FRAC      = 19;
  localparam int HEIGHT_FRAC    = 12;
  localparam int COMP_BITS      = 21;
  localparam int VEC_W          = 63;
  localparam int HEIGHT_W       = 32;
  localparam int SHIFT_W        = 42;
  localparam int SIZE_W         = 13;
  localparam int H_SHIFT        = STEP_FRAC - HEIGHT_FRAC;
  localparam int H19_W          = HEIGHT_W + H_SHIFT;
  localparam int CFG_INDEX_W    = 3;
  localparam int QUEUE_DEPTH    = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ORIGIN = 3'd0,
    REG_STEP_X = 3'd1,
    REG_STEP_Y = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_SHIFT  = 3'd4,
    REG_SRC_W  = 3'd5,
    REG_SRC_H  = 3'd6
  } cfg_reg_t;

  function automatic int imax(int a, int b);
    return (a > b) ? a : b;
  endfunction

  // Bits that lift a FRAC_BITS position to the internal 19-bit fraction.
  function automatic int scale_shift(int f);
    return STEP_FRAC - f;
  endfunction

  // Floor point component: scaled origin plus two coordinate products.
  function automatic int p_width(int c, int f);
    return imax(COMP_BITS + scale_shift(f), c + 1 + COMP_BITS) + 2;
  endfunction

  function automatic int den_width(int c, int f);
    return imax(p_width(c, f), H19_W + 1) + 1;
  endfunction

  // Quotient bits kept; anything at or above 2^n lands outside every image.
  function automatic int quot_bits(int c, int f);
    return imax(c + STEP_FRAC, COMP_BITS - 1 + scale_shift(f)) + 1;
  endfunction

  function automatic int val_width(int c, int f);
    return imax(p_width(c, f), quot_bits(c, f) + 2);
  endfunction

  function automatic logic signed [COMP_BITS-1:0] comp(logic [VEC_W-1:0] v, int k);
    return $signed(v[COMP_BITS*k +: COMP_BITS]);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pipm_front.sv]
// Front end: accepts destination pixels and forms the floor point and projection denominator.
`default_nettype none

module pipm_front import pipm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int P_W   = p_width(COORD_BITS, FRAC_BITS),
  localparam int DEN_W = den_width(COORD_BITS, FRAC_BITS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COORD_BITS-1:0]   dest_x,
  input  logic [COORD_BITS-1:0]   dest_y,
  input  logic [VEC_W-1:0]        origin,
  input  logic [VEC_W-1:0]        step_x,
  input  logic [VEC_W-1:0]        step_y,
  input  logic [HEIGHT_W-1:0]     height,
  output logic                    f_valid,
  input  logic                    f_ready,
  output logic signed [P_W-1:0]   px,
  output logic signed [P_W-1:0]   py,
  output logic signed [DEN_W-1:0] den
);

  localparam int MW = COORD_BITS + 1 + COMP_BITS;
  localparam int SH = scale_shift(FRAC_BITS);

  logic                  en;
  logic                  v1;
  logic signed [MW-1:0]  mx [3];
  logic signed [MW-1:0]  my [3];
  logic signed [P_W-1:0] p [3];
  logic signed [DEN_W-1:0] h19;

  assign en       = !f_valid || f_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      f_valid <= 1'b0;
    end else if (en) begin
      v1      <= in_valid;
      f_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mx[k] <= MW'($signed({1'b0, dest_x})) * MW'(comp(step_x, k));
        my[k] <= MW'($signed({1'b0, dest_y})) * MW'(comp(step_y, k));
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p[k] = (P_W'(comp(origin, k)) <<< SH) + P_W'(mx[k]) + P_W'(my[k]);
    end
    h19 = DEN_W'($signed({1'b0, height, {H_SHIFT{1'b0}}}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px  <= p[0];
      py  <= p[1];
      den <= h19 - DEN_W'(p[2]);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pipm_queue.sv]
// Short FIFO between the front end and the projection back end.
`default_nettype none

module pipm_queue import pipm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = count != CNT_W'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

endmodule

`default_nettype wire

[hw/rtl/pipm_lane.sv]
// One projected coordinate: product with the height, then a pipelined restoring divider.
`default_nettype none

module pipm_lane import pipm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int P_W   = p_width(COORD_BITS, FRAC_BITS),
  localparam int MAG_W = P_W - 1,
  localparam int D_W   = den_width(COORD_BITS, FRAC_BITS) - 1,
  localparam int V_W   = val_width(COORD_BITS, FRAC_BITS)
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic                  zero,
  input  logic                  neg,
  input  logic signed [P_W-1:0] pc,
  input  logic [MAG_W-1:0]      mag,
  input  logic [D_W-1:0]        dmag,
  input  logic [HEIGHT_W-1:0]   height,
  output logic signed [V_W-1:0] value
);

  localparam int QB   = quot_bits(COORD_BITS, FRAC_BITS);
  localparam int LO_W = MAG_W / 2;
  localparam int HI_W = MAG_W - LO_W;
  localparam int PL_W = LO_W + HEIGHT_W;
  localparam int PH_W = HI_W + HEIGHT_W;
  localparam int N_W  = MAG_W + H19_W;
  localparam int T_W  = N_W - QB;
  localparam int CW   = imax(T_W, D_W);

  // product stage
  logic [PL_W-1:0]       pp_lo;
  logic [PH_W-1:0]       pp_hi;
  logic                  s1_zero, s1_neg;
  logic signed [P_W-1:0] s1_pc;
  logic [D_W-1:0]        s1_d;
  // sum stage
  logic [N_W-1:0]        n;
  logic                  s2_zero, s2_neg;
  logic signed [P_W-1:0] s2_pc;
  logic [D_W-1:0]        s2_d;
  logic [T_W-1:0]        top;
  // divider stages
  logic [D_W-1:0]        dr   [QB+1];
  logic [QB-1:0]         dq   [QB+1];
  logic [QB-1:0]         dn   [QB+1];
  logic [D_W-1:0]        dd   [QB+1];
  logic                  dz   [QB+1];
  logic                  dneg [QB+1];
  logic                  dsat [QB+1];
  logic signed [P_W-1:0] dpc  [QB+1];
  logic [QB:0]           qf;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_lo   <= PL_W'(mag[LO_W-1:0]) * PL_W'(height);
      pp_hi   <= PH_W'(mag[MAG_W-1:LO_W]) * PH_W'(height);
      s1_zero <= zero;
      s1_neg  <= neg;
      s1_pc   <= pc;
      s1_d    <= dmag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n       <= ((N_W'(pp_hi) << LO_W) + N_W'(pp_lo)) << H_SHIFT;
      s2_zero <= s1_zero;
      s2_neg  <= s1_neg;
      s2_pc   <= s1_pc;
      s2_d    <= s1_d;
    end
  end

  assign top = n[N_W-1:QB];

  // Saturate when the quotient would not fit; otherwise the top part seeds the remainder.
  always_ff @(posedge clk) begin
    if (en) begin
      dsat[0] <= CW'(top) >= CW'(s2_d);
      dr[0]   <= D_W'(top);
      dq[0]   <= '0;
      dn[0]   <= n[QB-1:0];
      dd[0]   <= s2_d;
      dz[0]   <= s2_zero;
      dneg[0] <= s2_neg;
      dpc[0]  <= s2_pc;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [D_W:0] r2;
    logic         ge;

    assign r2 = {dr[j], dn[j][QB-1]};
    assign ge = r2 >= {1'b0, dd[j]};

    always_ff @(posedge clk) begin
      if (en) begin
        dr[j+1]   <= ge ? D_W'(r2 - {1'b0, dd[j]}) : D_W'(r2);
        dq[j+1]   <= {dq[j][QB-2:0], ge};
        dn[j+1]   <= dn[j] << 1;
        dd[j+1]   <= dd[j];
        dz[j+1]   <= dz[j];
        dneg[j+1] <= dneg[j];
        dsat[j+1] <= dsat[j];
        dpc[j+1]  <= dpc[j];
      end
    end
  end

  assign qf = dsat[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, dq[QB]};

  always_ff @(posedge clk) begin
    if (en) begin
      if (dz[QB])        value <= V_W'(dpc[QB]);
      else if (dneg[QB]) value <= -$signed(V_W'(qf));
      else               value <= $signed(V_W'(qf));
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pipm_back.sv]
// Back end: signs and magnitudes, two projection lanes, centre shift and range check.
`default_nettype none

module pipm_back import pipm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int P_W   = p_width(COORD_BITS, FRAC_BITS),
  localparam int DEN_W = den_width(COORD_BITS, FRAC_BITS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  logic signed [P_W-1:0]   q_px,
  input  logic signed [P_W-1:0]   q_py,
  input  logic signed [DEN_W-1:0] q_den,
  input  logic [HEIGHT_W-1:0]     height,
  input  logic [SHIFT_W-1:0]      shift,
  input  logic [SIZE_W-1:0]       src_w,
  input  logic [SIZE_W-1:0]       src_h,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COORD_BITS-1:0]   source_x,
  output logic [COORD_BITS-1:0]   source_y,
  output logic                    pixel_inside
);

  localparam int MAG_W = P_W - 1;
  localparam int D_W   = DEN_W - 1;
  localparam int QB    = quot_bits(COORD_BITS, FRAC_BITS);
  localparam int V_W   = val_width(COORD_BITS, FRAC_BITS);
  localparam int SH    = scale_shift(FRAC_BITS);
  localparam int S_W   = imax(V_W, COMP_BITS + SH) + 1;
  localparam int IP_W  = S_W - STEP_FRAC;
  localparam int LM_W  = imax(COORD_BITS, SIZE_W) + 1;
  localparam int LAT   = QB + 4;

  logic                    en;
  logic                    vb [LAT+1];
  logic signed [P_W-1:0]   ax, ay;
  logic signed [DEN_W-1:0] ad;
  logic                    b_zero, b_negx, b_negy;
  logic signed [P_W-1:0]   b_px, b_py;
  logic [MAG_W-1:0]        b_magx, b_magy;
  logic [D_W-1:0]          b_dmag;
  logic signed [V_W-1:0]   vx, vy;
  logic signed [S_W-1:0]   sx, sy;
  logic [IP_W-1:0]         ipx, ipy;
  logic                    okx, oky;

  assign en      = !out_valid || out_ready;
  assign q_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LAT; i++) vb[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vb[0] <= q_valid;
      for (int i = 1; i <= LAT; i++) vb[i] <= vb[i-1];
      out_valid <= vb[LAT];
    end
  end

  always_comb begin
    ax = q_px[P_W-1] ? -q_px : q_px;
    ay = q_py[P_W-1] ? -q_py : q_py;
    ad = q_den[DEN_W-1] ? -q_den : q_den;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_zero <= q_den == '0;
      b_negx <= q_px[P_W-1] ^ q_den[DEN_W-1];
      b_negy <= q_py[P_W-1] ^ q_den[DEN_W-1];
      b_px   <= q_px;
      b_py   <= q_py;
      b_magx <= ax[MAG_W-1:0];
      b_magy <= ay[MAG_W-1:0];
      b_dmag <= ad[D_W-1:0];
    end
  end

  pipm_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk(clk), .en(en), .zero(b_zero), .neg(b_negx), .pc(b_px), .mag(b_magx),
    .dmag(b_dmag), .height(height), .value(vx)
  );

  pipm_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk(clk), .en(en), .zero(b_zero), .neg(b_negy), .pc(b_py), .mag(b_magy),
    .dmag(b_dmag), .height(height), .value(vy)
  );

  // Add the centre shift back, then drop anything negative or past the image edge.
  always_comb begin
    sx  = S_W'(vx) + (S_W'(comp(VEC_W'(shift), 0)) <<< SH);
    sy  = S_W'(vy) + (S_W'(comp(VEC_W'(shift), 1)) <<< SH);
    ipx = sx[S_W-1:STEP_FRAC];
    ipy = sy[S_W-1:STEP_FRAC];
    okx = !sx[S_W-1] && ((ipx >> COORD_BITS) == '0)
          && (LM_W'(ipx[COORD_BITS-1:0]) < LM_W'(src_w));
    oky = !sy[S_W-1] && ((ipy >> COORD_BITS) == '0)
          && (LM_W'(ipy[COORD_BITS-1:0]) < LM_W'(src_h));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel_inside <= okx && oky;
      source_x     <= (okx && oky) ? ipx[COORD_BITS-1:0] : '0;
      source_y     <= (okx && oky) ? ipy[COORD_BITS-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/perspective_inverse_pixel_map_unit.sv]
// Top level: configuration registers, front end, queue and projection back end.
//
//   channel  direction  transfer when          payload
//   in       input      in_valid & in_ready    dest_x, dest_y
//   out      output     out_valid & out_ready  source_x, source_y, pixel_inside
//   cfg      input      cfg_write              cfg_index, cfg_data
//
// One pixel per cycle sustained while out_ready stays high; the divider
// pipeline computes one quotient bit per stage.
// Reset clears the registers, the queue and all valid bits.
// A stalled output holds the back end; the front end keeps filling the queue
// until it is full, then deasserts in_ready.
`default_nettype none

module perspective_inverse_pixel_map_unit import pipm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [VEC_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_BITS-1:0]  dest_x,
  input  logic [COORD_BITS-1:0]  dest_y,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_BITS-1:0]  source_x,
  output logic [COORD_BITS-1:0]  source_y,
  output logic                   pixel_inside
);

  localparam int P_W   = p_width(COORD_BITS, FRAC_BITS);
  localparam int DEN_W = den_width(COORD_BITS, FRAC_BITS);
  localparam int QW    = 2 * P_W + DEN_W;

  logic [VEC_W-1:0]    origin_xyz, step_x_xyz, step_y_xyz;
  logic [HEIGHT_W-1:0] observer_height;
  logic [SHIFT_W-1:0]  centre_shift;
  logic [SIZE_W-1:0]   source_width, source_height;

  logic                    f_valid, f_ready;
  logic signed [P_W-1:0]   f_px, f_py;
  logic signed [DEN_W-1:0] f_den;
  logic                    q_valid, q_ready;
  logic [QW-1:0]           q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_xyz      <= '0;
      step_x_xyz      <= '0;
      step_y_xyz      <= '0;
      observer_height <= '0;
      centre_shift    <= '0;
      source_width    <= '0;
      source_height   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ORIGIN: origin_xyz      <= cfg_data;
        REG_STEP_X: step_x_xyz      <= cfg_data;
        REG_STEP_Y: step_y_xyz      <= cfg_data;
        REG_HEIGHT: observer_height <= cfg_data[HEIGHT_W-1:0];
        REG_SHIFT:  centre_shift    <= cfg_data[SHIFT_W-1:0];
        REG_SRC_W:  source_width    <= cfg_data[SIZE_W-1:0];
        REG_SRC_H:  source_height   <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  pipm_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .dest_x(dest_x), .dest_y(dest_y),
    .origin(origin_xyz), .step_x(step_x_xyz), .step_y(step_y_xyz),
    .height(observer_height),
    .f_valid(f_valid), .f_ready(f_ready), .px(f_px), .py(f_py), .den(f_den)
  );

  pipm_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data({f_px, f_py, f_den}),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  pipm_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready),
    .q_px(q_data[QW-1 -: P_W]), .q_py(q_data[DEN_W +: P_W]),
    .q_den(q_data[DEN_W-1:0]),
    .height(observer_height), .shift(centre_shift),
    .src_w(source_width), .src_h(source_height),
    .out_valid(out_valid), .out_ready(out_ready),
    .source_x(source_x), .source_y(source_y), .pixel_inside(pixel_inside)
  );

endmodule

`default_nettype wire
